// ----- hw/rtl/rbe_pkg.sv -----
package rbe_pkg;

	// Default depth of the difference store.
	localparam int MAX_BLOCK_DEF = 32;

	// Configuration register indexes and port width.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_CODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b1;

	// Sample size codes.
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	localparam logic [1:0] SIZE_CODE_RST = SIZE_WORD;
	localparam logic [5:0] BLOCK_SIZE_RST = 6'd32;

	// Source and length selection of the bit packer.
	typedef enum logic [2:0] {
		PUSH_RAW,
		PUSH_ID,
		PUSH_DIRECT,
		PUSH_Z32,
		PUSH_UNARY,
		PUSH_LOW
	} push_sel_t;

	typedef struct packed {
		logic      take;
		logic      item;
		logic      div_init;
		logic      div_step;
		logic      push;
		push_sel_t sel;
		logic      j_clr;
		logic      j_inc;
		logic      load_val;
		logic      clr_block;
		logic      flush;
		logic      finish;
	} cmd_t;

	typedef struct packed {
		logic started;
		logic last;
		logic fill_hits;
		logic push_ok;
		logic div_last;
		logic is_direct;
		logic is_zero;
		logic zeros_ge32;
		logic split_nz;
		logic j_last;
		logic count_nz;
	} stat_t;

	// Width of the block id field.
	function automatic logic [5:0] id_bits(input logic [1:0] code);
		unique case (code)
			SIZE_BYTE: id_bits = 6'd3;
			SIZE_HALF: id_bits = 6'd4;
			default:   id_bits = 6'd5;
		endcase
	endfunction

	// Smallest split that falls back to direct codes; smaller ones are coded as Rice.
	function automatic logic [5:0] code_limit(input logic [1:0] code);
		unique case (code)
			SIZE_BYTE: code_limit = 6'd6;
			SIZE_HALF: code_limit = 6'd14;
			default:   code_limit = 6'd25;
		endcase
	endfunction

	// Sample width in bits, which is also the direct code width.
	function automatic logic [5:0] sample_bits(input logic [1:0] code);
		unique case (code)
			SIZE_BYTE: sample_bits = 6'd8;
			SIZE_HALF: sample_bits = 6'd16;
			default:   sample_bits = 6'd32;
		endcase
	endfunction

endpackage

// ----- hw/rtl/rbe_ctrl.sv -----
module rbe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rbe_pkg::stat_t st,
	output rbe_pkg::cmd_t  cmd
);
	import rbe_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ITEM  = 4'd1;
	localparam logic [3:0] S_DINIT = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_ID    = 4'd4;
	localparam logic [3:0] S_DRD   = 4'd5;
	localparam logic [3:0] S_DVAL  = 4'd6;
	localparam logic [3:0] S_RRD   = 4'd7;
	localparam logic [3:0] S_RVAL  = 4'd8;
	localparam logic [3:0] S_RZ    = 4'd9;
	localparam logic [3:0] S_RLOW  = 4'd10;
	localparam logic [3:0] S_CLOSE = 4'd11;
	localparam logic [3:0] S_FLUSH = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.sel = PUSH_RAW;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_ITEM;
				end
			end
			S_ITEM: begin
				if (st.started || st.push_ok) begin
					cmd.item = 1'b1;
					cmd.push = !st.started;
					cmd.sel = PUSH_RAW;
					state_d = (st.last || st.fill_hits) ? S_DINIT : S_DONE;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_ID;
				end
			end
			S_ID: begin
				if (st.push_ok) begin
					cmd.push = 1'b1;
					cmd.sel = PUSH_ID;
					cmd.j_clr = 1'b1;
					priority if (st.is_direct) begin
						state_d = S_DRD;
					end else if (st.is_zero) begin
						state_d = S_CLOSE;
					end else begin
						state_d = S_RRD;
					end
				end
			end
			S_DRD: begin
				state_d = S_DVAL;
			end
			S_DVAL: begin
				if (st.push_ok) begin
					cmd.push = 1'b1;
					cmd.sel = PUSH_DIRECT;
					if (st.j_last) begin
						state_d = S_CLOSE;
					end else begin
						cmd.j_inc = 1'b1;
						state_d = S_DRD;
					end
				end
			end
			S_RRD: begin
				state_d = S_RVAL;
			end
			S_RVAL: begin
				cmd.load_val = 1'b1;
				state_d = S_RZ;
			end
			S_RZ: begin
				if (st.push_ok) begin
					cmd.push = 1'b1;
					if (st.zeros_ge32) begin
						cmd.sel = PUSH_Z32;
					end else begin
						cmd.sel = PUSH_UNARY;
						priority if (st.split_nz) begin
							state_d = S_RLOW;
						end else if (st.j_last) begin
							state_d = S_CLOSE;
						end else begin
							cmd.j_inc = 1'b1;
							state_d = S_RRD;
						end
					end
				end
			end
			S_RLOW: begin
				if (st.push_ok) begin
					cmd.push = 1'b1;
					cmd.sel = PUSH_LOW;
					if (st.j_last) begin
						state_d = S_CLOSE;
					end else begin
						cmd.j_inc = 1'b1;
						state_d = S_RRD;
					end
				end
			end
			S_CLOSE: begin
				cmd.clr_block = 1'b1;
				state_d = st.last ? S_FLUSH : S_DONE;
			end
			S_FLUSH: begin
				if (!st.count_nz) begin
					state_d = S_DONE;
				end else if (st.push_ok) begin
					cmd.flush = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (st.push_ok) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/rbe_datapath.sv -----
module rbe_datapath #(
	parameter int MAX_BLOCK = rbe_pkg::MAX_BLOCK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rbe_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [rbe_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic signed [31:0]            sample,
	input  logic                          last_sample,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [31:0]                   code_word,
	output logic [2:0]                    valid_bytes,
	output logic                          run_last,
	output logic                          stream_end,
	input  rbe_pkg::cmd_t                 cmd,
	output rbe_pkg::stat_t                st
);
	import rbe_pkg::*;

	localparam int IDXW  = $clog2(MAX_BLOCK);
	localparam int FILLW = $clog2(MAX_BLOCK + 1);
	localparam int SUMW  = 32 + $clog2(MAX_BLOCK);
	localparam int QLW   = $clog2(SUMW + 1);
	localparam int DCW   = $clog2(SUMW);
	localparam int RW    = FILLW + 1;

	logic [1:0]       size_code_q;
	logic [5:0]       block_size_q;
	logic [31:0]      sample_q;
	logic             last_q;
	logic [31:0]      prev_q;
	logic             started_q;
	logic [FILLW-1:0] fill_q;
	logic [SUMW-1:0]  sum_q;
	logic [31:0]      mem [MAX_BLOCK];
	logic [31:0]      rdata_q;
	logic [IDXW-1:0]  j_q;
	logic [SUMW-1:0]  dvd_q;
	logic [RW-1:0]    rem_q;
	logic [DCW-1:0]   div_cnt_q;
	logic [QLW-1:0]   qlen_q;
	logic [31:0]      v_q;
	logic [31:0]      zeros_q;
	logic [30:0]      acc_q;
	logic [4:0]       cnt_q;
	logic [31:0]      pend_q;
	logic [2:0]       pend_bytes_q;
	logic             pend_valid_q;
	logic             out_valid_q;
	logic [31:0]      out_word_q;
	logic [2:0]       out_bytes_q;
	logic             out_last_q;
	logic             out_end_q;

	// Sample decode.
	logic [5:0]       bits;
	logic [31:0]      raw;
	logic [31:0]      value;
	logic [31:0]      diff;
	logic [31:0]      mapped;
	logic [FILLW-1:0] limit_eff;
	logic [5:0]       limit;
	logic [QLW-1:0]   split;
	logic [31:0]      id_val;
	logic [SUMW-1:0]  half;
	logic [RW-1:0]    r2;
	logic             r_ge;

	// Bit packer.
	logic [31:0] pv;
	logic [5:0]  pn;
	logic [32:0] vmask;
	logic [62:0] cat;
	logic [6:0]  tot;
	logic        emit;
	logic [31:0] pword;
	logic [30:0] pacc;
	logic [62:0] amask;
	logic [31:0] fword;
	logic [2:0]  fbytes;
	logic        out_free;
	logic        new_word;
	logic [31:0] new_word_val;
	logic [2:0]  new_word_bytes;

	always_comb begin
		bits = sample_bits(size_code_q);
		limit = code_limit(size_code_q);
		unique case (size_code_q)
			SIZE_BYTE: begin
				raw = {24'd0, sample_q[7:0]};
				value = {{24{sample_q[7]}}, sample_q[7:0]};
			end
			SIZE_HALF: begin
				raw = {16'd0, sample_q[15:0]};
				value = {{16{sample_q[15]}}, sample_q[15:0]};
			end
			default: begin
				raw = sample_q;
				value = sample_q;
			end
		endcase
		diff = started_q ? (value - prev_q) : 32'd0;
		mapped = {diff[30:0], 1'b0} ^ {32{diff[31]}};
		if (block_size_q == 6'd0 || {2'b00, block_size_q} > 8'(MAX_BLOCK)) begin
			limit_eff = FILLW'(MAX_BLOCK);
		end else begin
			limit_eff = FILLW'(block_size_q);
		end
		split = (qlen_q == '0) ? '0 : qlen_q - QLW'(1);
		half = SUMW'(fill_q >> 1);
		r2 = {rem_q[RW-2:0], dvd_q[SUMW-1]};
		r_ge = r2 >= RW'(fill_q);
	end

	always_comb begin
		st.started = started_q;
		st.last = last_q;
		st.fill_hits = ({1'b0, fill_q} + (FILLW+1)'(1)) >= {1'b0, limit_eff};
		st.push_ok = !pend_valid_q || out_free;
		st.div_last = (div_cnt_q == '0);
		st.is_direct = 8'(split) >= 8'(limit);
		st.is_zero = (split == '0) && (sum_q == '0);
		st.zeros_ge32 = |zeros_q[31:5];
		st.split_nz = qlen_q > QLW'(1);
		st.j_last = (FILLW'(j_q) + FILLW'(1)) == fill_q;
		st.count_nz = (cnt_q != 5'd0);
	end

	always_comb begin
		priority if (st.is_direct) begin
			id_val = {26'd0, limit} + 32'd1;
		end else if (st.is_zero) begin
			id_val = 32'd0;
		end else begin
			id_val = 32'(split) + 32'd1;
		end
	end

	// Appends pn bits of pv below the pending bits; a full word drops out on top.
	always_comb begin
		unique case (cmd.sel)
			PUSH_RAW: begin
				pv = raw;
				pn = bits;
			end
			PUSH_ID: begin
				pv = id_val;
				pn = id_bits(size_code_q);
			end
			PUSH_DIRECT: begin
				pv = rdata_q;
				pn = bits;
			end
			PUSH_Z32: begin
				pv = 32'd0;
				pn = 6'd32;
			end
			PUSH_UNARY: begin
				pv = 32'd1;
				pn = {1'b0, zeros_q[4:0]} + 6'd1;
			end
			PUSH_LOW: begin
				pv = v_q;
				pn = 6'(split);
			end
			default: begin
				pv = 32'd0;
				pn = 6'd0;
			end
		endcase
		vmask = (33'd1 << pn) - 33'd1;
		cat = ({32'd0, acc_q} << pn) | {31'd0, pv & vmask[31:0]};
		tot = {2'b00, cnt_q} + {1'b0, pn};
		emit = tot >= 7'd32;
		pword = 32'(cat >> tot[4:0]);
		amask = (63'd1 << tot[4:0]) - 63'd1;
		pacc = 31'(cat & amask);
		fword = {1'b0, acc_q} << (6'd32 - {1'b0, cnt_q});
		fbytes = 3'(({1'b0, cnt_q} + 6'd7) >> 3);
		out_free = !out_valid_q || !out_stall;
		new_word = (cmd.push && emit) || cmd.flush;
		new_word_val = cmd.flush ? fword : pword;
		new_word_bytes = cmd.flush ? fbytes : 3'd4;
	end

	// Difference store, one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (cmd.item) begin
			mem[fill_q[IDXW-1:0]] <= mapped;
		end
		rdata_q <= mem[j_q];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= sample;
		end
		if (cmd.j_clr) begin
			j_q <= '0;
		end else if (cmd.j_inc) begin
			j_q <= j_q + IDXW'(1);
		end
		if (cmd.div_init) begin
			dvd_q <= (sum_q >= half + SUMW'(1)) ? (sum_q - half - SUMW'(1)) : '0;
			rem_q <= '0;
			div_cnt_q <= DCW'(SUMW - 1);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SUMW-2:0], 1'b0};
			rem_q <= r_ge ? (r2 - RW'(fill_q)) : r2;
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
		if (cmd.load_val) begin
			v_q <= rdata_q;
			zeros_q <= rdata_q >> split;
		end else if (cmd.push && cmd.sel == PUSH_Z32) begin
			zeros_q <= zeros_q - 32'd32;
		end
		if (new_word) begin
			pend_q <= new_word_val;
			pend_bytes_q <= new_word_bytes;
		end
		// The output stage only takes a word that is really pending, and words move
		// only on push_ok, so a stalled output word is never overwritten.
		if ((new_word || cmd.finish) && pend_valid_q) begin
			out_word_q <= pend_q;
			out_bytes_q <= pend_bytes_q;
			out_last_q <= cmd.finish;
			out_end_q <= cmd.finish && last_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_code_q <= SIZE_CODE_RST;
			block_size_q <= BLOCK_SIZE_RST;
			last_q <= 1'b0;
			prev_q <= 32'd0;
			started_q <= 1'b0;
			fill_q <= '0;
			sum_q <= '0;
			qlen_q <= '0;
			acc_q <= 31'd0;
			cnt_q <= 5'd0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_SIZE_CODE:  size_code_q <= wr_data[1:0];
					REG_BLOCK_SIZE: block_size_q <= wr_data[5:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				last_q <= last_sample;
			end
			if (cmd.item) begin
				prev_q <= value;
				started_q <= 1'b1;
				fill_q <= fill_q + FILLW'(1);
				sum_q <= sum_q + SUMW'(mapped);
			end
			if (cmd.div_init) begin
				qlen_q <= '0;
			end else if (cmd.div_step && r_ge && qlen_q == '0) begin
				qlen_q <= QLW'(div_cnt_q) + QLW'(1);
			end
			if (cmd.push) begin
				if (emit) begin
					acc_q <= pacc;
					cnt_q <= tot[4:0];
				end else begin
					acc_q <= cat[30:0];
					cnt_q <= tot[4:0];
				end
			end else if (cmd.flush) begin
				acc_q <= 31'd0;
				cnt_q <= 5'd0;
			end
			if (cmd.clr_block) begin
				fill_q <= '0;
				sum_q <= '0;
			end
			if (cmd.finish && last_q) begin
				prev_q <= 32'd0;
				started_q <= 1'b0;
				fill_q <= '0;
				sum_q <= '0;
				acc_q <= 31'd0;
				cnt_q <= 5'd0;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (new_word) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign code_word = out_word_q;
	assign valid_bytes = out_bytes_q;
	assign run_last = out_last_q;
	assign stream_end = out_end_q;

endmodule

// ----- hw/rtl/rice_block_encoder.sv -----
// Rice block encoder for a stream of signed 1, 2 or 4 byte samples.
// Input channel: sample and last_sample with in_valid/in_stall; an item is
// taken when in_valid is high and in_stall low. Output channel: code_word,
// valid_bytes, run_last and stream_end with out_valid/out_stall, where the
// receiver drives out_stall. Registers are to be written through wr_en,
// wr_index and wr_data, and only while the encoder is idle; the block does
// not enforce this. An item that does not close a block is stored and
// finished before the next acceptance. Closing a block adds a set-up step,
// a mean divider step per dividend bit, a step each for the block id and
// the block clear, a read and a push per direct-coded sample, or a read, a
// load and one or two pushes per Rice-coded sample plus a push per 32 extra
// zeros; a stream's last item also passes a flush step for its partial word.
// The last word of an item is held back one stage so that run_last and
// stream_end can be set on it; the first word of an item appears on the
// output as the second word is packed or as the item finishes.
// Reset clears the stream, the packer and the output stage and restores the
// registers to four byte samples and blocks of 32. A stalling receiver holds
// the output word; the packer then waits, and in_stall stays high until the
// item has been fully handed over.
module rice_block_encoder #(
	parameter int MAX_BLOCK = rbe_pkg::MAX_BLOCK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            sample,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   code_word,
	output logic [2:0]                    valid_bytes,
	output logic                          run_last,
	output logic                          stream_end,
	input  logic                          wr_en,
	input  logic [rbe_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [rbe_pkg::CFG_DATA_W-1:0] wr_data
);
	import rbe_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// The controller sequences sample intake, the mean divider and the
	// coding of each stored difference.
	rbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the registers, the store, the divider and the packer.
	rbe_datapath #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.sample      (sample),
		.last_sample (last_sample),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.code_word   (code_word),
		.valid_bytes (valid_bytes),
		.run_last    (run_last),
		.stream_end  (stream_end),
		.cmd         (cmd),
		.st          (st)
	);

	// The end of a stream is always the end of an item's words.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_last)
		else $error("stream_end without run_last");

	// Only the flushed word of a stream may be partly filled.
	a_partial_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_bytes != 3'd4 |-> stream_end && valid_bytes != 3'd0)
		else $error("partial word before the end of the stream");

	// An accepted item is worked on before another is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is being coded");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import rbe_pkg::*;

	// The spare size code, which the encoder treats as four-byte samples.
	localparam logic [1:0] SIZE_SPARE = 2'd3;
	// Cycles without any accepted item or register write before the run is declared hung.
	localparam int HANG_LIMIT = 4000;
	// Length of the long receiver hold-off.
	localparam int HOLD_CYCLES = 400;
	// Settling time before a register write and at the end of the run.
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        run_last;
		logic        stream_end;
	} code_word_t;

	// Scoreboard: keeps its own copy of the encoder state and registers, works out
	// the packed words that each accepted sample causes, and checks the words that
	// come out against them in order.
	class rice_scoreboard;
		logic [1:0]  size_code = SIZE_CODE_RST;
		logic [5:0]  blk_size = BLOCK_SIZE_RST;
		logic [31:0] diffs[MAX_BLOCK_DEF];
		logic [63:0] sum;
		logic [31:0] prev;
		int unsigned fill;
		bit          started;
		logic [63:0] acc;
		int unsigned nbits;
		code_word_t  step_words[$];
		code_word_t  expected[$];
		int          errors;

		function void clear_stream();
			sum = 0;
			prev = 0;
			fill = 0;
			started = 0;
			acc = 0;
			nbits = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_SIZE_CODE)
				size_code = data[1:0];
			else
				blk_size = data;
		endfunction

		// Appends n bits (1 to 32), most significant first, and sends a full word.
		function void append_bits(logic [31:0] value, int unsigned n);
			code_word_t w;
			acc = (acc << n) | (value & ((64'd1 << n) - 1));
			nbits += n;
			if (nbits >= 32) begin
				w.word = 32'(acc >> (nbits - 32));
				w.nbytes = 3'd4;
				w.run_last = 1'b0;
				w.stream_end = 1'b0;
				step_words.push_back(w);
				nbits -= 32;
				acc &= (64'd1 << nbits) - 1;
			end
		endfunction

		function void code_block();
			int unsigned idbits, limit, width, split, zeros;
			logic [63:0] half, q;
			logic [31:0] p, v;
			idbits = (size_code == SIZE_BYTE) ? 3 : (size_code == SIZE_HALF) ? 4 : 5;
			limit = (size_code == SIZE_BYTE) ? 6 : (size_code == SIZE_HALF) ? 14 : 25;
			width = 1 << idbits;
			if (fill == 0)
				return;
			half = fill / 2;
			q = 0;
			if (sum >= half + 1)
				q = (sum - half - 1) / fill;
			p = q[32:1];
			split = 0;
			while (p != 0) begin
				split++;
				p >>= 1;
			end
			if (split >= limit) begin
				append_bits(limit + 1, idbits);
				for (int j = 0; j < fill; j++)
					append_bits(diffs[j], width);
			end else if (split == 0 && sum == 0) begin
				// All differences zero: only the zero-block id is sent.
				append_bits(0, idbits);
			end else begin
				append_bits(split + 1, idbits);
				for (int j = 0; j < fill; j++) begin
					v = diffs[j];
					zeros = v >> split;
					while (zeros >= 32) begin
						append_bits(0, 32);
						zeros -= 32;
					end
					append_bits(1, zeros + 1);
					if (split > 0)
						append_bits(v, split);
				end
			end
			fill = 0;
			sum = 0;
		endfunction

		function void note_sample(logic [31:0] smp, logic last);
			int unsigned bits, limit;
			logic [31:0] raw, value, d, m;
			code_word_t w;
			bits = (size_code == SIZE_BYTE) ? 8 : (size_code == SIZE_HALF) ? 16 : 32;
			raw = (bits == 32) ? smp : smp & ((32'd1 << bits) - 1);
			value = (bits == 32) ? raw : ((raw ^ (32'd1 << (bits - 1))) - (32'd1 << (bits - 1)));
			limit = blk_size;
			if (limit == 0 || limit > MAX_BLOCK_DEF)
				limit = MAX_BLOCK_DEF;
			step_words.delete();
			if (!started) begin
				// The first sample of a stream goes out raw.
				append_bits(raw, bits);
				prev = value;
				started = 1;
			end
			d = value - prev;
			m = (d << 1) ^ {32{d[31]}};
			prev = value;
			if (fill < MAX_BLOCK_DEF) begin
				diffs[fill] = m;
				fill++;
				sum += m;
			end
			if (last || fill >= limit)
				code_block();
			if (last) begin
				if (nbits > 0) begin
					w.word = 32'(acc << (32 - nbits));
					w.nbytes = 3'((nbits + 7) / 8);
					w.run_last = 1'b0;
					w.stream_end = 1'b0;
					step_words.push_back(w);
				end
				if (step_words.size() > 0)
					step_words[step_words.size() - 1].stream_end = 1'b1;
				clear_stream();
			end
			if (step_words.size() > 0)
				step_words[step_words.size() - 1].run_last = 1'b1;
			foreach (step_words[i])
				expected.push_back(step_words[i]);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_word(code_word_t got);
			code_word_t exp;
			if (expected.size() == 0) begin
				report($sformatf("unexpected word %08h", got.word));
				return;
			end
			exp = expected.pop_front();
			if (got.word !== exp.word)
				report($sformatf("code_word %08h, expected %08h", got.word, exp.word));
			if (got.nbytes !== exp.nbytes)
				report($sformatf("valid_bytes %0d, expected %0d", got.nbytes, exp.nbytes));
			if (got.run_last !== exp.run_last)
				report($sformatf("run_last %b, expected %b", got.run_last, exp.run_last));
			if (got.stream_end !== exp.stream_end)
				report($sformatf("stream_end %b, expected %b", got.stream_end, exp.stream_end));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic signed [31:0]    sample;
	logic                  last_sample;
	logic                  out_valid;
	logic                  out_stall;
	logic [31:0]           code_word;
	logic [2:0]            valid_bytes;
	logic                  run_last;
	logic                  stream_end;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	rice_scoreboard sb = new();
	// Idling on both sides is switched off for the closing part of the run.
	bit             idling = 1;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit             hold_req = 0;
	logic [31:0]    last_driven = 0;
	int             hang_count = 0;

	rice_block_encoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.last_sample(last_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_word(code_word),
		.valid_bytes(valid_bytes),
		.run_last(run_last),
		.stream_end(stream_end),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Accepted items on both channels are sampled here, at the edge that takes
	// them; the values seen are those from before the edge.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_sample(sample, last_sample);
		if (out_valid && !out_stall)
			sb.check_word({code_word, valid_bytes, run_last, stream_end});
	end

	// Watchdog: counts cycles in which neither channel moves an item and no register is written.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
			hang_count <= 0;
		else
			hang_count <= hang_count + 1;
		if (hang_count >= HANG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, and none at
	// all once idling has been switched off.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else if (idling && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// Offers one item and waits for the encoder to take it. Valid stays high for
	// a following item unless a gap is drawn.
	task send_sample(logic [31:0] smp, logic last);
		in_valid <= 1'b1;
		sample <= smp;
		last_sample <= last;
		last_driven = smp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0)
			@(posedge clk);
	endtask

	// Registers are written only with nothing in flight: an item that caused no
	// word may still be in the encoder, so some cycles are let pass first.
	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Random samples: mostly small steps from the last one so that Rice codes of
	// many splits appear, some full-range values for direct codes, and repeats
	// for zero blocks.
	task random_samples(int count);
		logic [31:0] smp;
		int          kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 2)
				smp = $urandom();
			else if (kind < 8)
				smp = last_driven + ($urandom() >> $urandom_range(11, 31))
					- ($urandom() >> $urandom_range(11, 31));
			else
				smp = last_driven;
			send_sample(smp, $urandom_range(0, 14) == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		last_sample = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with one-byte samples and blocks of eight.
		write_reg(REG_SIZE_CODE, SIZE_BYTE);
		write_reg(REG_BLOCK_SIZE, 6'd8);
		// A stream of one sample only.
		send_sample(32'h0000_0080, 1'b1);
		// Eight equal samples give a zero block.
		for (int i = 0; i < 8; i++)
			send_sample(32'hFFFF_FF7F, 1'b0);
		// Alternating extremes force direct codes.
		for (int i = 0; i < 8; i++)
			send_sample((i % 2) ? 32'h0000_0080 : 32'h1234_567F, 1'b0);
		// Small steps give Rice codes; the stream ends in a partial block.
		for (int i = 0; i < 5; i++)
			send_sample(32'h10 + i * 3, i == 4);

		// Full-width extremes with the reset block size.
		write_reg(REG_SIZE_CODE, SIZE_WORD);
		write_reg(REG_BLOCK_SIZE, 6'd32);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);

		// Random phases over several settings, the odd ones among them.
		write_reg(REG_SIZE_CODE, SIZE_HALF);
		write_reg(REG_BLOCK_SIZE, 6'd16);
		random_samples(15);

		// The receiver holds off while items keep coming, so the encoder fills up.
		write_reg(REG_SIZE_CODE, SIZE_WORD);
		write_reg(REG_BLOCK_SIZE, 6'd32);
		hold_req = 1;
		random_samples(20);
		send_sample($urandom(), 1'b1);

		write_reg(REG_SIZE_CODE, SIZE_SPARE);
		write_reg(REG_BLOCK_SIZE, 6'd0);
		random_samples(10);
		// The sender pauses until every word has come, mid-stream.
		drain();
		random_samples(8);

		write_reg(REG_SIZE_CODE, SIZE_BYTE);
		write_reg(REG_BLOCK_SIZE, 6'd12);
		random_samples(15);

		// Block size above the store depth, and lowered part-way through a block.
		write_reg(REG_SIZE_CODE, SIZE_WORD);
		write_reg(REG_BLOCK_SIZE, 6'd63);
		random_samples(10);
		write_reg(REG_BLOCK_SIZE, 6'd8);
		random_samples(8);

		// Closing part without any idling.
		idling = 0;
		write_reg(REG_SIZE_CODE, SIZE_HALF);
		random_samples(10);
		send_sample($urandom(), 1'b1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.expected.size() != 0)
			sb.report($sformatf("%0d words never arrived", sb.expected.size()));
		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/rbe_pkg.sv
hw/rtl/rbe_ctrl.sv
hw/rtl/rbe_datapath.sv
hw/rtl/rice_block_encoder.sv
dv/tb_top.sv
